// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the depth-first walk RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property holds at every clock edge outside reset
`define DFSAM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge
`define DFSAM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define DFSAM_ASSERT(label, clk, rst, prop, msg)
`define DFSAM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/dfsam_pkg.sv =====
// Types, constants and helpers for the depth-first adjacency matrix walk
`default_nettype none

package dfsam_pkg;

  localparam int MAX_NODES = 64;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int COUNT_W   = NODE_W + 1;

  localparam logic [COUNT_W-1:0] NODE_COUNT_RST = COUNT_W'(MAX_NODES);

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_EDGE  = 2'd1;
  localparam logic [1:0] MODE_WALK  = 2'd2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [NODE_W-1:0] first_node;
    logic [NODE_W-1:0] second_node;
    logic [NODE_W-1:0] start_node;
  } dfsam_in_t;

  typedef struct packed {
    logic [NODE_W-1:0] visited_node;
    logic              last_visit;
  } dfsam_out_t;

  // Adjacency memory request: clear, set one bit, read one row
  typedef struct packed {
    logic              clear;
    logic              wr_en;
    logic [NODE_W-1:0] wr_row;
    logic [NODE_W-1:0] wr_col;
    logic              rd_en;
    logic [NODE_W-1:0] rd_row;
  } adj_req_t;

  // Stack memory request: one write, one read
  typedef struct packed {
    logic              wr_en;
    logic [NODE_W-1:0] wr_addr;
    logic [NODE_W-1:0] wr_data;
    logic              rd_en;
    logic [NODE_W-1:0] rd_addr;
  } stack_req_t;

  // Lowest set bit: {hit, index}. Groups of eight, then the bit inside the group.
  function automatic logic [NODE_W:0] first_set(input logic [MAX_NODES-1:0] v);
    logic [7:0] grp_any;
    logic [7:0] sub;
    logic [2:0] g;
    logic [2:0] b;
    logic       hit;
    for (int i = 0; i < 8; i++) begin
      grp_any[i] = |v[i*8 +: 8];
    end
    g   = '0;
    hit = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (grp_any[i]) begin
        g   = 3'(i);
        hit = 1'b1;
      end
    end
    sub = v[g*8 +: 8];
    b   = '0;
    for (int i = 7; i >= 0; i--) begin
      if (sub[i]) begin
        b = 3'(i);
      end
    end
    return {hit, g, b};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dfsam_adj_mem.sv =====
// Adjacency matrix memory: one row per node, row valid bits for fast clear
`default_nettype none

module dfsam_adj_mem
  import dfsam_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire adj_req_t             req,
  output logic [MAX_NODES-1:0]      rd_data
);

  logic [MAX_NODES-1:0] mem [MAX_NODES];
  logic [MAX_NODES-1:0] row_valid;
  logic [MAX_NODES-1:0] rd_q;
  logic                 rd_valid;

  // Bit set into a live row, or a fresh one-hot row over stale contents
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      if (row_valid[req.wr_row]) begin
        mem[req.wr_row][req.wr_col] <= 1'b1;
      end else begin
        mem[req.wr_row] <= MAX_NODES'(1) << req.wr_col;
      end
    end
    if (req.rd_en) begin
      rd_q <= mem[req.rd_row];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (req.clear) begin
        row_valid <= '0;
      end else if (req.wr_en) begin
        row_valid[req.wr_row] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid <= row_valid[req.rd_row];
      end
    end
  end

  assign rd_data = rd_valid ? rd_q : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/dfsam_stack_mem.sv =====
// Walk stack memory: node indices, one write and one registered read a cycle
`default_nettype none

module dfsam_stack_mem
  import dfsam_pkg::*;
(
  input  wire logic               clk,
  input  wire stack_req_t         req,
  output logic [NODE_W-1:0]       rd_data
);

  logic [NODE_W-1:0] mem [MAX_NODES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dfs_adjacency_matrix_walk.sv =====
// Top level: depth-first walk over a bit adjacency matrix
//
//   channel   direction  handshake              beat
//   in        input      in_valid / in_ready    dfsam_in_t  (mode, nodes)
//   out       output     out_valid / out_ready  dfsam_out_t (node, last flag)
//   cfg       input      cfg_wr_en              node_count, 7 bits
//
// Clear drops every row valid bit; an edge makes one matrix write per direction.
// A walk pushes the start node and reads its row, then each push reads the new node's row;
// a pop is a stack read, then a row read (ST_POP); the walk ends when the last stack entry has no open neighbour.
// Results lag one node behind the walk so the last one can be flagged.
// Synchronous reset empties the matrix at once through row valid bits; node_count returns to 64.
// A full output register stalls pushes and the final emit; input is taken only between items.
`default_nettype none
`include "assert_macros.svh"

module dfs_adjacency_matrix_walk
  import dfsam_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire dfsam_in_t           in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output dfsam_out_t               out_item,
  input  wire logic                cfg_wr_en,
  input  wire logic [COUNT_W-1:0]  cfg_wr_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EDGE = 2'd1;
  localparam logic [1:0] ST_EVAL = 2'd2;
  localparam logic [1:0] ST_POP  = 2'd3;

  logic [1:0]           state;
  logic [COUNT_W-1:0]   node_count;
  logic [COUNT_W-1:0]   height;
  logic [MAX_NODES-1:0] visited;
  logic [NODE_W-1:0]    top_node;
  logic [NODE_W-1:0]    pend_node;
  logic [NODE_W-1:0]    edge_row;
  logic [NODE_W-1:0]    edge_col;

  adj_req_t             adj_req;
  stack_req_t           stk_req;
  logic [MAX_NODES-1:0] adj_rdata;
  logic [NODE_W-1:0]    stk_rdata;

  logic                 accept;
  logic [COUNT_W-1:0]   n_active;
  logic [MAX_NODES-1:0] node_mask;
  logic                 a_ok;
  logic                 b_ok;
  logic                 s_ok;
  logic [MAX_NODES-1:0] cand;
  logic [NODE_W:0]      ffs;
  logic                 found;
  logic [NODE_W-1:0]    next_node;
  logic                 slot_free;
  logic                 emit;
  logic                 emit_last;

  dfsam_adj_mem u_adj (
    .clk     (clk),
    .rst     (rst),
    .req     (adj_req),
    .rd_data (adj_rdata)
  );

  dfsam_stack_mem u_stack (
    .clk     (clk),
    .req     (stk_req),
    .rd_data (stk_rdata)
  );

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign n_active  = (node_count > COUNT_W'(MAX_NODES)) ? COUNT_W'(MAX_NODES) : node_count;
  assign node_mask = (n_active >= COUNT_W'(MAX_NODES)) ? '1
                   : ((MAX_NODES'(1) << n_active) - MAX_NODES'(1));
  assign a_ok      = {1'b0, in_item.first_node}  < n_active;
  assign b_ok      = {1'b0, in_item.second_node} < n_active;
  assign s_ok      = {1'b0, in_item.start_node}  < n_active;
  assign cand      = adj_rdata & node_mask & ~visited & ~(MAX_NODES'(1) << top_node);
  assign ffs       = first_set(cand);
  assign found     = ffs[NODE_W];
  assign next_node = ffs[NODE_W-1:0];
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    adj_req   = '0;
    stk_req   = '0;
    emit      = 1'b0;
    emit_last = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (in_item.mode)
            MODE_CLEAR: begin
              adj_req.clear = 1'b1;
            end
            MODE_EDGE: begin
              adj_req.wr_en  = a_ok && b_ok;
              adj_req.wr_row = in_item.first_node;
              adj_req.wr_col = in_item.second_node;
            end
            MODE_WALK: begin
              adj_req.rd_en   = s_ok;
              adj_req.rd_row  = in_item.start_node;
              stk_req.wr_en   = s_ok;
              stk_req.wr_addr = '0;
              stk_req.wr_data = in_item.start_node;
            end
            default: begin
            end
          endcase
        end
      end
      ST_EDGE: begin
        adj_req.wr_en  = 1'b1;
        adj_req.wr_row = edge_row;
        adj_req.wr_col = edge_col;
      end
      ST_EVAL: begin
        if (found) begin
          // push: hand the pending node out, fetch the new node's row
          if (slot_free) begin
            emit            = 1'b1;
            adj_req.rd_en   = 1'b1;
            adj_req.rd_row  = next_node;
            stk_req.wr_en   = 1'b1;
            stk_req.wr_addr = height[NODE_W-1:0];
            stk_req.wr_data = next_node;
          end
        end else if (height == COUNT_W'(1)) begin
          emit      = slot_free;
          emit_last = 1'b1;
        end else begin
          // pop: fetch the entry below the top
          stk_req.rd_en   = 1'b1;
          stk_req.rd_addr = NODE_W'(height - COUNT_W'(2));
        end
      end
      ST_POP: begin
        adj_req.rd_en  = 1'b1;
        adj_req.rd_row = stk_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      node_count <= NODE_COUNT_RST;
      height     <= '0;
      visited    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        node_count <= cfg_wr_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (in_item.mode)
              MODE_EDGE: begin
                if (a_ok && b_ok) begin
                  state <= ST_EDGE;
                end
              end
              MODE_WALK: begin
                if (s_ok) begin
                  visited <= MAX_NODES'(1) << in_item.start_node;
                  height  <= COUNT_W'(1);
                  state   <= ST_EVAL;
                end else begin
                  visited <= '0;
                  height  <= '0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_EDGE: begin
          state <= ST_IDLE;
        end
        ST_EVAL: begin
          if (found) begin
            if (slot_free) begin
              visited <= visited | (MAX_NODES'(1) << next_node);
              height  <= height + COUNT_W'(1);
            end
          end else if (height == COUNT_W'(1)) begin
            if (slot_free) begin
              height <= '0;
              state  <= ST_IDLE;
            end
          end else begin
            height <= height - COUNT_W'(1);
            state  <= ST_POP;
          end
        end
        ST_POP: begin
          state <= ST_EVAL;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      edge_row  <= in_item.second_node;
      edge_col  <= in_item.first_node;
      top_node  <= in_item.start_node;
      pend_node <= in_item.start_node;
    end else if (state == ST_EVAL && found && slot_free) begin
      top_node  <= next_node;
      pend_node <= next_node;
    end else if (state == ST_POP) begin
      top_node  <= stk_rdata;
    end
    if (emit) begin
      out_item.visited_node <= pend_node;
      out_item.last_visit   <= emit_last;
    end
  end

  `DFSAM_ASSERT(a_height_bound, clk, rst, height <= COUNT_W'(MAX_NODES), "stack height overflow")
  `DFSAM_ASSERT(a_walk_nonempty, clk, rst, (state != ST_EVAL && state != ST_POP) || (height != '0), "walk running on empty stack")
  `DFSAM_ASSERT(a_top_visited, clk, rst, (state != ST_EVAL) || visited[top_node], "stack top not marked visited")
  `DFSAM_ASSERT_NEXT(a_walk_start, clk, rst, accept && in_item.mode == MODE_WALK && s_ok, state == ST_EVAL && height == COUNT_W'(1), "walk did not start")

endmodule

`default_nettype wire

// ===== bench/dfs_preorder_checker.sv =====
// Checker for the depth-first walk: predicts the preorder visits and compares each output beat
`timescale 1ns / 1ps

module dfs_preorder_checker
  import dfsam_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  dfsam_in_t          in_item,
  input  logic               out_valid,
  input  logic               out_ready,
  input  dfsam_out_t         out_item,
  input  logic               cfg_wr_en,
  input  logic [COUNT_W-1:0] cfg_wr_data,
  output int                 mismatches,
  output int                 visits_due,
  output int                 visits_checked
);

  logic [MAX_NODES-1:0] adj_rows [MAX_NODES];
  logic [COUNT_W-1:0]   node_count;
  dfsam_out_t           preorder_due [$];

  initial begin
    mismatches     = 0;
    visits_due     = 0;
    visits_checked = 0;
  end

  task automatic report(input string what, input int want, input int got);
    mismatches++;
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endtask

  // Apply one input beat to the shadow graph; queue the visits a walk produces
  task automatic predict_preorder(input dfsam_in_t beat);
    int unsigned          n;
    int                   depth;
    int                   top;
    int                   nxt;
    logic [MAX_NODES-1:0] in_use;
    logic [MAX_NODES-1:0] seen;
    logic [MAX_NODES-1:0] open_nbrs;
    logic [NODE_W-1:0]    path [MAX_NODES];
    dfsam_out_t           visit;
    n = (node_count > COUNT_W'(MAX_NODES)) ? MAX_NODES : node_count;
    case (beat.mode)
      MODE_CLEAR: begin
        foreach (adj_rows[i]) adj_rows[i] = '0;
      end
      MODE_EDGE: begin
        if (beat.first_node < n && beat.second_node < n) begin
          adj_rows[beat.first_node][beat.second_node] = 1'b1;
          adj_rows[beat.second_node][beat.first_node] = 1'b1;
        end
      end
      MODE_WALK: begin
        // a start outside the nodes in use walks nowhere
        if (beat.start_node < n) begin
          in_use = '1;
          if (n < MAX_NODES) in_use = (MAX_NODES'(1) << n) - MAX_NODES'(1);
          seen = '0;
          seen[beat.start_node] = 1'b1;
          path[0] = beat.start_node;
          depth = 1;
          visit.visited_node = beat.start_node;
          visit.last_visit   = 1'b0;
          preorder_due = {preorder_due, visit};
          while (depth > 0) begin
            top = path[depth-1];
            open_nbrs = adj_rows[top] & in_use & ~seen;
            // self-loops stay stored but are never followed
            open_nbrs[top] = 1'b0;
            if (open_nbrs == '0) begin
              depth--;
            end else begin
              nxt = 0;
              while (!open_nbrs[nxt]) nxt++;
              seen[nxt] = 1'b1;
              path[depth] = NODE_W'(nxt);
              depth++;
              visit.visited_node = NODE_W'(nxt);
              preorder_due = {preorder_due, visit};
            end
          end
          // flag the final visit of this walk
          visit = preorder_due[preorder_due.size() - 1];
          visit.last_visit = 1'b1;
          preorder_due[preorder_due.size() - 1] = visit;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : track
    dfsam_out_t want;
    if (rst) begin
      foreach (adj_rows[i]) adj_rows[i] = '0;
      node_count = NODE_COUNT_RST;
      preorder_due.delete();
    end else begin
      // results always trail the beat that caused them, so drain before predicting
      if (out_valid && out_ready) begin
        visits_checked++;
        if (preorder_due.size() == 0) begin
          mismatches++;
          $display("%0t ns: visit beat with nothing pending, expected none, got node %0d last %0b",
                   $time, out_item.visited_node, out_item.last_visit);
        end else begin
          want = preorder_due.pop_front();
          if (out_item.visited_node !== want.visited_node)
            report("visited_node", want.visited_node, out_item.visited_node);
          if (out_item.last_visit !== want.last_visit)
            report("last_visit", want.last_visit, out_item.last_visit);
        end
      end
      if (in_valid && in_ready) predict_preorder(in_item);
      if (cfg_wr_en) node_count = cfg_wr_data;
    end
    visits_due = preorder_due.size();
  end

endmodule

// ===== bench/dfs_adjacency_matrix_walk_tb.sv =====
// Testbench top: drives clear, edge and walk beats and node-count writes, then gives the verdict
`timescale 1ns / 1ps

module dfs_adjacency_matrix_walk_tb;
  import dfsam_pkg::*;

  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  localparam int         DRAIN_CYCLES = 400;
  localparam int         LONG_HOLD    = 600;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  dfsam_in_t          in_item = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  dfsam_out_t         out_item;
  logic               cfg_wr_en = 1'b0;
  logic [COUNT_W-1:0] cfg_wr_data = '0;

  int          mismatches;
  int          visits_due;
  int          visits_checked;
  int          send_gap_pct = 9;
  int          recv_gap_pct = 57;
  bit          long_hold_req = 1'b0;
  int unsigned node_count = MAX_NODES;
  int          beats_sent = 0;
  int          counts_tried = 1;

  always #4 clk = ~clk;

  dfs_adjacency_matrix_walk DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  dfs_preorder_checker walk_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_item       (out_item),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .mismatches     (mismatches),
    .visits_due     (visits_due),
    .visits_checked (visits_checked)
  );

  // Receiver: random stalls, plus one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  // Offer one beat and hold it until accepted; enter and leave on a rising edge
  task automatic send_beat(input logic [1:0] mode, input int unsigned a, b, s);
    dfsam_in_t beat;
    beat.mode        = mode;
    beat.first_node  = NODE_W'(a);
    beat.second_node = NODE_W'(b);
    beat.start_node  = NODE_W'(s);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  // Drop valid, wait for every pending visit, then let a silent walk finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (visits_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_node_count(input int unsigned value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= COUNT_W'(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    node_count = value;
    counts_tried++;
  endtask

  // Sequences: optional clear, a burst of edges, then walks, with occasional out-of-range nodes and unused modes
  task automatic random_traffic(input int beats);
    int unsigned span;
    int unsigned width;
    int unsigned base;
    int          done;
    span = (node_count > MAX_NODES) ? MAX_NODES : node_count;
    if (span == 0) span = 1;
    done = 0;
    while (done < beats) begin
      if ($urandom_range(3) == 0) begin
        send_beat(MODE_CLEAR, $urandom_range(63), $urandom_range(63), $urandom_range(63));
        done++;
      end
      // either scatter edges over all nodes or pack them into a small cluster
      width = ($urandom_range(1) == 0 || span < 8) ? span : 8;
      base  = $urandom_range(span - width);
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(19) == 0) begin
          send_beat(MODE_EDGE, $urandom_range(63), $urandom_range(63), $urandom_range(63));
        end else begin
          send_beat(MODE_EDGE, base + $urandom_range(width - 1),
                    base + $urandom_range(width - 1), $urandom_range(63));
          done++;
        end
      end
      repeat ($urandom_range(1, 3)) begin
        send_beat(MODE_WALK, $urandom_range(63), $urandom_range(63),
                  ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(span - 1));
        done++;
      end
      if ($urandom_range(29) == 0)
        send_beat(MODE_UNUSED, $urandom_range(63), $urandom_range(63), $urandom_range(63));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty graph, unused mode, small cycle, self-loop, field extremes
    send_beat(MODE_WALK, 0, 0, 0);
    send_beat(MODE_UNUSED, 63, 63, 63);
    send_beat(MODE_EDGE, 0, 63, 0);
    send_beat(MODE_EDGE, 0, 1, 0);
    send_beat(MODE_EDGE, 1, 2, 0);
    send_beat(MODE_EDGE, 2, 0, 0);
    send_beat(MODE_EDGE, 5, 5, 0);
    send_beat(MODE_EDGE, 63, 62, 0);
    send_beat(MODE_WALK, 0, 0, 0);
    send_beat(MODE_WALK, 0, 0, 5);
    send_beat(MODE_WALK, 63, 63, 63);
    // shrink the count: stored edges beyond it stay but are skipped
    set_node_count(4);
    send_beat(MODE_EDGE, 3, 5, 0);
    send_beat(MODE_EDGE, 1, 3, 0);
    send_beat(MODE_WALK, 0, 0, 0);
    send_beat(MODE_WALK, 0, 0, 4);
    send_beat(MODE_WALK, 0, 0, 63);
    // oversized count acts as the full node range
    set_node_count(127);
    send_beat(MODE_EDGE, 62, 3, 0);
    send_beat(MODE_WALK, 0, 0, 62);
    set_node_count(0);
    send_beat(MODE_EDGE, 0, 1, 0);
    send_beat(MODE_WALK, 0, 0, 0);
    set_node_count(1);
    send_beat(MODE_WALK, 0, 0, 0);
    send_beat(MODE_CLEAR, 0, 0, 0);
    send_beat(MODE_WALK, 0, 0, 0);

    set_node_count(64);
    random_traffic(75);
    set_node_count($urandom_range(2, 16));
    random_traffic(50);

    send_gap_pct = 57;
    recv_gap_pct = 9;
    set_node_count(127);
    random_traffic(55);
    set_node_count($urandom_range(17, 63));
    random_traffic(50);

    send_gap_pct = 0;
    recv_gap_pct = 0;
    set_node_count(64);
    random_traffic(40);
    // long chain, then hold the output while walks pile up behind it
    send_beat(MODE_CLEAR, 0, 0, 0);
    for (int i = 0; i < 15; i++) send_beat(MODE_EDGE, i, i + 1, 0);
    long_hold_req = 1'b1;
    repeat (4) send_beat(MODE_WALK, 0, 0, $urandom_range(15));
    set_node_count(2);
    random_traffic(30);
    set_node_count(1);
    random_traffic(15);
    set_node_count(0);
    random_traffic(10);
    set_node_count($urandom_range(17, 63));
    random_traffic(45);

    wait_idle();
    $display("Sent %0d input beats over %0d node-count settings, zero and oversized included.",
             beats_sent, counts_tried);
    $display("Checked %0d visit beats under stalls on both sides and one long output hold.",
             visits_checked);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== dfs_adjacency_matrix_walk.f =====
+incdir+hw/rtl
hw/rtl/dfsam_pkg.sv
hw/rtl/dfsam_adj_mem.sv
hw/rtl/dfsam_stack_mem.sv
hw/rtl/dfs_adjacency_matrix_walk.sv
bench/dfs_preorder_checker.sv
bench/dfs_adjacency_matrix_walk_tb.sv
